[rtl/lkv_pkg.sv]
`default_nettype none

package lkv_pkg;

  // Port field widths.
  localparam int unsigned ReqTypeW   = 2;
  localparam int unsigned KeyPortW   = 32;
  localparam int unsigned ValPortW   = 32;
  localparam int unsigned CountPortW = 5;

  // Parameter defaults.
  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned ValueBitsDef  = 32;

  // Request kinds. The fourth code behaves as a lookup.
  localparam logic [ReqTypeW-1:0] ReqLookup = 2'd0;
  localparam logic [ReqTypeW-1:0] ReqPut    = 2'd1;
  localparam logic [ReqTypeW-1:0] ReqRemove = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift,
    StFinish
  } seq_state_e;

  typedef struct packed {
    logic                  status;
    logic [CountPortW-1:0] count;
    logic [ValPortW-1:0]   value;
    logic                  found;
  } result_t;

endpackage

`default_nettype wire

[rtl/linear_key_value_table.sv]
// An accepted request scans the entries (at least one), a remove then shifts the entries
// behind the match down by one, and the result passes through an output register to the output.
// The block takes no new request until its result has been taken by the output register;
// the scan is done by the single key comparator that checks one entry per cycle.
// Reset clears the entry count and the handshake state; table contents are not cleared.
`default_nettype none

module linear_key_value_table #(
  parameter int unsigned TABLE_DEPTH = lkv_pkg::TableDepthDef,
  parameter int unsigned KEY_BITS    = lkv_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS  = lkv_pkg::ValueBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // req_key [31:0], req_value [63:32]
  input  wire logic [1:0]  s_axis_tuser,  // req_type [1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // found_value [31:0], entries_in_use [36:32]
  output logic [1:0]       m_axis_tuser   // key_found [0], status [1]
);

  import lkv_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_q;
  logic    out_valid_q;

  lkv_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .req_key_i   (s_axis_tdata[31:0]),
    .req_value_i (s_axis_tdata[63:32]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.count, out_q.value};
  assign m_axis_tuser  = {out_q.status, out_q.found};

  // A rejected put never matched a key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status) |-> !res.found)
    else $error("rejected put reports a found key");

  // A put is rejected only when the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status) |-> (res.count == CountPortW'(TABLE_DEPTH)))
    else $error("put rejected while table has room");

  // The block takes one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A pending result blocks new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("ready asserted with a result pending");

endmodule

`default_nettype wire

[rtl/lkv_mem.sv]
`default_nettype none

module lkv_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       wr_en_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                           wr_data_i,
  input  wire logic                                       rd_en_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                           rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/lkv_seq.sv]
`default_nettype none

module lkv_seq #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire logic [lkv_pkg::ReqTypeW-1:0]  req_type_i,
  input  wire logic [lkv_pkg::KeyPortW-1:0]  req_key_i,
  input  wire logic [lkv_pkg::ValPortW-1:0]  req_value_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output lkv_pkg::result_t                   res_o
);

  import lkv_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = CW + 1;
  localparam int unsigned KW = (KEY_BITS < KeyPortW) ? KEY_BITS : KeyPortW;
  localparam int unsigned VW = (VALUE_BITS < ValPortW) ? VALUE_BITS : ValPortW;
  localparam int unsigned EW = KW + VW;

  seq_state_e            state_q, state_d;
  logic [ReqTypeW-1:0]   type_q, type_d;
  logic [KW-1:0]         key_q, key_d;
  logic [VW-1:0]         value_q, value_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  found_q, found_d;
  logic [VW-1:0]         old_q, old_d;
  logic                  status_q, status_d;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [EW-1:0]         rd_data;

  logic [IW-1:0]         next_idx;
  logic                  more;
  logic                  hit;

  lkv_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The read data always holds the entry at idx_q while scanning or shifting.
  assign next_idx = IW'(idx_q) + IW'(1);
  assign more     = next_idx < IW'(count_q);
  assign hit      = (rd_data[EW-1:VW] == key_q) && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    key_q    <= key_d;
    value_q  <= value_d;
    idx_q    <= idx_d;
    found_q  <= found_d;
    old_q    <= old_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    key_d       = key_q;
    value_d     = value_q;
    idx_d       = idx_q;
    count_d     = count_q;
    found_d     = found_q;
    old_d       = old_q;
    status_d    = status_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = {key_q, value_q};
    rd_en       = 1'b0;
    rd_addr     = AW'(next_idx);
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          type_d   = req_type_i;
          key_d    = req_key_i[KW-1:0];
          value_d  = req_value_i[VW-1:0];
          found_d  = 1'b0;
          old_d    = '0;
          status_d = 1'b0;
          idx_d    = '0;
          rd_en    = 1'b1;
          rd_addr  = '0;
          state_d  = StScan;
        end
      end

      StScan: begin
        if (hit) begin
          found_d = 1'b1;
          old_d   = rd_data[VW-1:0];
          state_d = StFinish;
          case (type_q)
            ReqPut: begin
              wr_en = 1'b1;
            end
            ReqRemove: begin
              if (more) begin
                rd_en   = 1'b1;
                idx_d   = AW'(next_idx);
                state_d = StShift;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            default: begin
            end
          endcase
        end else if (more) begin
          rd_en = 1'b1;
          idx_d = AW'(next_idx);
        end else begin
          state_d = StFinish;
          if (type_q == ReqPut) begin
            if (count_q < CW'(TABLE_DEPTH)) begin
              wr_en   = 1'b1;
              wr_addr = AW'(count_q);
              count_d = count_q + CW'(1);
            end else begin
              status_d = 1'b1;
            end
          end
        end
      end

      StShift: begin
        // Move the entry at idx_q down by one to close the gap.
        wr_en   = 1'b1;
        wr_addr = idx_q - AW'(1);
        wr_data = rd_data;
        if (more) begin
          rd_en = 1'b1;
          idx_d = AW'(next_idx);
        end else begin
          count_d = count_q - CW'(1);
          state_d = StFinish;
        end
      end

      StFinish: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    res_o        = '0;
    res_o.found  = found_q;
    res_o.value  = ValPortW'(old_q);
    res_o.status = status_q;
    res_o.count  = CountPortW'(count_q);
  end

endmodule

`default_nettype wire
